FILE: hdl/run_length_record_encoder_macros.svh
// Assertion macros used by the checker file of the run-length record encoder.
`ifndef RUN_LENGTH_RECORD_ENCODER_MACROS_SVH
`define RUN_LENGTH_RECORD_ENCODER_MACROS_SVH

// Property checked on the rising clock edge while reset is low.
`define RLRE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RLRE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/rlre_pkg.sv
`default_nettype none
package rlre_pkg;

   // Field widths.
   localparam int SYMBOL_BITS     = 64;
   localparam int LENGTH_BITS     = 13;
   localparam int OUT_LENGTH_BITS = 32;
   localparam int TOTAL_BITS      = OUT_LENGTH_BITS + 1;

   // Default saturation width of an incoming run length.
   localparam int IN_LEN_BITS_DEFAULT = 13;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;
   localparam int SYM_BYTES_BITS = 4;
   localparam int RUN_BYTES_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYM_BYTES = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUN_BYTES = 2'd1;

   // Request operations.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Depth of the job queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef logic [SYMBOL_BITS-1:0]     sym_type;
   typedef logic [LENGTH_BITS-1:0]     len_type;
   typedef logic [OUT_LENGTH_BITS-1:0] out_len_type;
   typedef logic [TOTAL_BITS-1:0]      total_type;
   typedef logic [SYM_BYTES_BITS-1:0]  sym_bytes_type;
   typedef logic [RUN_BYTES_BITS-1:0]  run_bytes_type;

   typedef struct packed {
      logic    op;
      sym_type symbol;
      len_type run_length;
   } req_payload_type;

   typedef struct packed {
      sym_type     out_symbol;
      out_len_type out_length;
      logic        last;
   } rsp_payload_type;

   // One job for the back end: an optional record of the old run, then
   // full-size chunks of chunk_total while it exceeds the record limit.
   typedef struct packed {
      logic        old_valid;
      sym_type     old_symbol;
      out_len_type old_length;
      sym_type     chunk_symbol;
      total_type   chunk_total;
   } job_type;

   // Longest length a record may carry for a given run_bytes setting.
   function automatic out_len_type record_limit(input run_bytes_type run_bytes);
      out_len_type limit;
      case (run_bytes) inside
         3'd0, 3'd1: limit = 32'h0000_00FF;
         3'd2:       limit = 32'h0000_FFFF;
         3'd3:       limit = 32'h00FF_FFFF;
         default:    limit = 32'hFFFF_FFFF;
      endcase
      return limit;
   endfunction

   // Mask that keeps the low sym_bytes bytes of a symbol.
   function automatic sym_type symbol_mask(input sym_bytes_type sym_bytes);
      sym_type mask;
      case (sym_bytes) inside
         4'd0, 4'd1: mask = 64'h0000_0000_0000_00FF;
         4'd2:       mask = 64'h0000_0000_0000_FFFF;
         4'd3:       mask = 64'h0000_0000_00FF_FFFF;
         4'd4:       mask = 64'h0000_0000_FFFF_FFFF;
         4'd5:       mask = 64'h0000_00FF_FFFF_FFFF;
         4'd6:       mask = 64'h0000_FFFF_FFFF_FFFF;
         4'd7:       mask = 64'h00FF_FFFF_FFFF_FFFF;
         default:    mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/run_length_record_encoder.sv
// Run-length record encoder. Each request either adds a run of a symbol or
// flushes; runs of the same symbol are merged. Records of the full limit
// 2^(8*run_bytes)-1, run_bytes clamped to 1..4, go out as soon as a run
// exceeds it; a change of symbol or a flush sends the remainder out as one
// record, with last set on the final record of each request. The front end
// takes one request per cycle and hands any records to make, as a job, to a
// two-entry queue; the back end sends one record per cycle from its output
// register while the output is not stalled. A request gives one to 33 records
// or none; the front stalls only when the queue is full. Configuration must
// be written while no request is in flight; the block does not enforce it.
`default_nettype none
module run_length_record_encoder #(
   parameter int IN_LEN_BITS = rlre_pkg::IN_LEN_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [rlre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rlre_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire rlre_pkg::req_payload_type           req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output rlre_pkg::rsp_payload_type                rsp_payload
);

   logic                  push_valid;
   rlre_pkg::job_type     push_job;
   logic                  queue_full;
   logic                  pop;
   logic                  pop_valid;
   rlre_pkg::job_type     pop_job;
   rlre_pkg::out_len_type limit;

   // Front end: merges runs and classifies each request.
   rlre_front #(
      .IN_LEN_BITS (IN_LEN_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .queue_full       (queue_full),
      .limit            (limit)
   );

   // Job queue between the two halves.
   rlre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   // Back end: sends the records of each job.
   rlre_back u_back (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

FILE: hdl/rlre_front.sv
`default_nettype none
module rlre_front #(
   parameter int IN_LEN_BITS = rlre_pkg::IN_LEN_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [rlre_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [rlre_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire rlre_pkg::req_payload_type             req_payload,
   output logic                                       push_valid,
   output rlre_pkg::job_type                          push_job,
   input  wire logic                                  queue_full,
   output rlre_pkg::out_len_type                      limit
);

   // Saturation value of an incoming length, and the bit span of a merged
   // length when the record limit is one byte.
   localparam rlre_pkg::len_type LEN_CAP = rlre_pkg::len_type'((1 << IN_LEN_BITS) - 1);
   localparam int FOLD_BITS = IN_LEN_BITS + 1;

   rlre_pkg::sym_bytes_type sym_bytes_ff, sym_bytes_in;
   rlre_pkg::run_bytes_type run_bytes_ff, run_bytes_in;
   rlre_pkg::sym_type       pend_symbol_ff, pend_symbol_in;
   logic                    pend_valid_ff, pend_valid_in;
   rlre_pkg::out_len_type   pend_length_ff, pend_length_in;

   logic                    accept;
   logic                    flush;
   logic                    same;
   logic                    old_emit;
   logic                    chunk;
   rlre_pkg::sym_type       mask;
   rlre_pkg::len_type       len_sat;
   rlre_pkg::total_type     total;
   rlre_pkg::total_type     limit_wide;
   rlre_pkg::out_len_type   remain;
   logic [8:0]              fold_sum;
   logic [8:0]              fold_red;
   logic [7:0]              remain_small;

   assign limit      = rlre_pkg::record_limit(run_bytes_ff);
   assign mask       = rlre_pkg::symbol_mask(sym_bytes_ff);
   assign limit_wide = {1'b0, limit};

   // A request is taken whenever the job queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the request against the pending run.
   always_comb begin
      flush    = (req_payload.op == rlre_pkg::OP_FLUSH);
      len_sat  = (req_payload.run_length > LEN_CAP) ? LEN_CAP : req_payload.run_length;
      same     = pend_valid_ff && (req_payload.symbol == pend_symbol_ff);
      old_emit = pend_valid_ff && (pend_length_ff != '0) && (flush || !same);
      if (flush) begin
         total = '0;
      end else if (same) begin
         total = {1'b0, pend_length_ff} + rlre_pkg::total_type'(len_sat);
      end else begin
         total = rlre_pkg::total_type'(len_sat);
      end
      chunk = (total > limit_wide);
   end

   // Length left pending once the full-size chunks have gone out. With a
   // one-byte limit the merged length stays below twice the saturated input
   // span, so the remainder modulo 255 comes from folding the high byte into
   // the low byte; a nonzero multiple of 255 leaves a whole chunk pending.
   always_comb begin
      fold_sum     = 9'(total[FOLD_BITS-1:8]) + 9'(total[7:0]);
      fold_red     = (fold_sum > 9'd255) ? (fold_sum - 9'd255) : fold_sum;
      remain_small = (fold_red[7:0] == 8'd0) ? 8'hFF : fold_red[7:0];
      if (!chunk) begin
         remain = total[rlre_pkg::OUT_LENGTH_BITS-1:0];
      end else if (run_bytes_ff <= rlre_pkg::run_bytes_type'(1)) begin
         remain = rlre_pkg::out_len_type'(remain_small);
      end else begin
         remain = rlre_pkg::out_len_type'(total - limit_wide);
      end
   end

   // Job for the back end; requests that give no record make no job.
   always_comb begin
      push_valid            = accept && (old_emit || chunk);
      push_job.old_valid    = old_emit;
      push_job.old_symbol   = pend_symbol_ff & mask;
      push_job.old_length   = pend_length_ff;
      push_job.chunk_symbol = req_payload.symbol & mask;
      push_job.chunk_total  = total;
   end

   // Pending run and configuration registers.
   always_comb begin
      sym_bytes_in   = sym_bytes_ff;
      run_bytes_in   = run_bytes_ff;
      pend_symbol_in = pend_symbol_ff;
      pend_valid_in  = pend_valid_ff;
      pend_length_in = pend_length_ff;
      if (accept) begin
         if (flush) begin
            pend_symbol_in = '0;
            pend_valid_in  = 1'b0;
            pend_length_in = '0;
         end else begin
            pend_symbol_in = req_payload.symbol;
            pend_valid_in  = 1'b1;
            pend_length_in = remain;
         end
      end
      if (csr_write_enable) begin
         unique case (csr_index)
            rlre_pkg::CSR_SYM_BYTES: begin
               sym_bytes_in = csr_write_data[rlre_pkg::SYM_BYTES_BITS-1:0];
            end
            rlre_pkg::CSR_RUN_BYTES: begin
               run_bytes_in = csr_write_data[rlre_pkg::RUN_BYTES_BITS-1:0];
               // A smaller limit clips whatever is pending.
               if (pend_length_ff >
                   rlre_pkg::record_limit(csr_write_data[rlre_pkg::RUN_BYTES_BITS-1:0])) begin
                  pend_length_in =
                     rlre_pkg::record_limit(csr_write_data[rlre_pkg::RUN_BYTES_BITS-1:0]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_bytes_ff   <= rlre_pkg::sym_bytes_type'(1);
         run_bytes_ff   <= rlre_pkg::run_bytes_type'(1);
         pend_symbol_ff <= '0;
         pend_valid_ff  <= 1'b0;
         pend_length_ff <= '0;
      end else begin
         sym_bytes_ff   <= sym_bytes_in;
         run_bytes_ff   <= run_bytes_in;
         pend_symbol_ff <= pend_symbol_in;
         pend_valid_ff  <= pend_valid_in;
         pend_length_ff <= pend_length_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/rlre_queue.sv
`default_nettype none
module rlre_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire rlre_pkg::job_type  push_job,
   output logic                    full,
   input  wire logic               pop,
   output logic                    pop_valid,
   output rlre_pkg::job_type       pop_job
);

   localparam int PTR_BITS   = $clog2(rlre_pkg::QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(rlre_pkg::QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(rlre_pkg::QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   LAST_PTR    = PTR_BITS'(rlre_pkg::QUEUE_DEPTH - 1);

   rlre_pkg::job_type       entries_ff [rlre_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == DEPTH_COUNT);
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/rlre_back.sv
`default_nettype none
module rlre_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rlre_pkg::out_len_type  limit,
   input  wire logic                   pop_valid,
   input  wire rlre_pkg::job_type      pop_job,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rlre_pkg::rsp_payload_type   rsp_payload
);

   logic                      active_ff, active_in;
   logic                      old_ff, old_in;
   rlre_pkg::sym_type         old_symbol_ff, old_symbol_in;
   rlre_pkg::out_len_type     old_length_ff, old_length_in;
   rlre_pkg::sym_type         symbol_ff, symbol_in;
   rlre_pkg::total_type       remain_ff, remain_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rlre_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                      slot_free;
   logic                      emit;
   logic                      last_now;
   rlre_pkg::total_type       limit_wide;
   rlre_pkg::total_type       after_chunk;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign limit_wide  = {1'b0, limit};
   assign after_chunk = remain_ff - limit_wide;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign emit        = active_ff && slot_free;

   // The record that goes out now is the job's last one when nothing
   // larger than a chunk is left behind it.
   assign last_now = old_ff ? (remain_ff <= limit_wide) : (after_chunk <= limit_wide);

   // Take the next job when idle or while the current one sends its last record.
   assign pop = pop_valid && (!active_ff || (emit && last_now));

   always_comb begin
      active_in      = active_ff;
      old_in         = old_ff;
      old_symbol_in  = old_symbol_ff;
      old_length_in  = old_length_ff;
      symbol_in      = symbol_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      // The output register empties once its record has been taken.
      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      // Send one record: the old run first, then full-size chunks.
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_payload_in.last = last_now;
         if (old_ff) begin
            rsp_payload_in.out_symbol = old_symbol_ff;
            rsp_payload_in.out_length = old_length_ff;
            old_in                    = 1'b0;
         end else begin
            rsp_payload_in.out_symbol = symbol_ff;
            rsp_payload_in.out_length = limit;
            remain_in                 = after_chunk;
         end
         if (last_now) begin
            active_in = 1'b0;
         end
      end

      // Load a new job from the queue.
      if (pop) begin
         active_in     = 1'b1;
         old_in        = pop_job.old_valid;
         old_symbol_in = pop_job.old_symbol;
         old_length_in = pop_job.old_length;
         symbol_in     = pop_job.chunk_symbol;
         remain_in     = pop_job.chunk_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         old_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         old_ff       <= old_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_symbol_ff  <= old_symbol_in;
      old_length_ff  <= old_length_in;
      symbol_ff      <= symbol_in;
      remain_ff      <= remain_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
`default_nettype wire

FILE: hdl/rlre_checker.sv
`default_nettype none
`include "run_length_record_encoder_macros.svh"
module rlre_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                csr_write_enable,
   input wire logic [rlre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [rlre_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire rlre_pkg::req_payload_type           req_payload,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire rlre_pkg::rsp_payload_type           rsp_payload
);

   // A stalled record stays on the port unchanged.
   `RLRE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled record changed")

   // No record ever carries a zero length.
   `RLRE_ASSERT(a_rsp_length, clock, reset, rsp_valid |-> rsp_payload.out_length != '0, "record of zero length")

   // The output is empty in the cycle after reset.
   `RLRE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "record present after reset")

endmodule

bind run_length_record_encoder rlre_checker u_checker (.*);
`default_nettype wire

FILE: tb/run_length_record_encoder_checker.sv
`timescale 1ns / 100ps
// Watches the request, response and register ports of the run-length record
// encoder, keeps its own copy of the pending run and the settings, and
// compares every accepted record with the oldest one still owed.
module run_length_record_encoder_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rlre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlre_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  rlre_pkg::req_payload_type           req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  rlre_pkg::rsp_payload_type           rsp_payload,
   output int                                  records_due,
   output int                                  mismatch_count
);
   import rlre_pkg::*;

   // Settings as last written.
   sym_bytes_type sym_bytes_setting;
   run_bytes_type run_bytes_setting;

   // The run still being merged.
   sym_type       run_symbol;
   logic          run_open;
   logic [32:0]   run_total;

   // Records owed by the block, oldest first.
   rsp_payload_type owed_records[$];

   // The newest record of the request being predicted is held back so that
   // its last flag can be set once the request is fully worked out.
   rsp_payload_type held_record;
   logic            holding;

   // Longest length one record may carry under the current run_bytes.
   function automatic logic [32:0] chunk_limit();
      int nbytes;
      nbytes = run_bytes_setting;
      if (nbytes < 1) nbytes = 1;
      if (nbytes > 4) nbytes = 4;
      return (33'd1 << (8 * nbytes)) - 33'd1;
   endfunction

   // The pending symbol cut down to the low sym_bytes bytes.
   function automatic sym_type record_symbol();
      int      nbytes;
      sym_type mask;
      nbytes = sym_bytes_setting;
      if (nbytes < 1) nbytes = 1;
      mask = '1;
      if (nbytes < 8) mask = (64'd1 << (8 * nbytes)) - 64'd1;
      return run_symbol & mask;
   endfunction

   function automatic void emit_record(input logic [32:0] length);
      if (holding) owed_records.push_back(held_record);
      held_record.out_symbol = record_symbol();
      held_record.out_length = length[31:0];
      held_record.last       = 1'b0;
      holding                = 1'b1;
   endfunction

   // Works out the records that one accepted request causes and queues them.
   // The run length field is already at its saturation width, so no cap is
   // needed here.
   function automatic void encode_request(input req_payload_type request);
      logic [32:0] limit;
      limit   = chunk_limit();
      holding = 1'b0;
      if (request.op == OP_FLUSH) begin
         if (run_open && run_total != 0) emit_record(run_total);
         run_open   = 1'b0;
         run_symbol = '0;
         run_total  = '0;
      end else begin
         if (run_open && request.symbol == run_symbol) begin
            run_total = run_total + request.run_length;
         end else begin
            // A new symbol closes the old run, even when the new one is empty.
            if (run_open && run_total != 0) emit_record(run_total);
            run_symbol = request.symbol;
            run_open   = 1'b1;
            run_total  = 33'(request.run_length);
         end
         // Full chunks leave as soon as the run is over the limit.
         while (run_total > limit) begin
            emit_record(limit);
            run_total = run_total - limit;
         end
      end
      if (holding) begin
         held_record.last = 1'b1;
         owed_records.push_back(held_record);
         holding = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type oldest;
      if (reset) begin
         sym_bytes_setting = 4'd1;
         run_bytes_setting = 3'd1;
         run_symbol        = '0;
         run_open          = 1'b0;
         run_total         = '0;
         holding           = 1'b0;
         mismatch_count    = 0;
         owed_records.delete();
      end else begin
         // Register writes; a smaller record limit cuts the pending run down.
         if (csr_write_enable) begin
            if (csr_index == CSR_SYM_BYTES) begin
               sym_bytes_setting = csr_write_data[SYM_BYTES_BITS-1:0];
            end else if (csr_index == CSR_RUN_BYTES) begin
               run_bytes_setting = csr_write_data[RUN_BYTES_BITS-1:0];
               if (run_total > chunk_limit()) run_total = chunk_limit();
            end
         end

         // Compare each accepted record with the oldest one owed.
         if (rsp_valid && !rsp_stall) begin
            if (owed_records.size() == 0) begin
               $error("record %h/%h arrived with none expected",
                      rsp_payload.out_symbol, rsp_payload.out_length);
               mismatch_count++;
            end else begin
               oldest = owed_records.pop_front();
               if (rsp_payload.out_symbol !== oldest.out_symbol) begin
                  $error("out_symbol: expected %h, actual %h",
                         oldest.out_symbol, rsp_payload.out_symbol);
                  mismatch_count++;
               end
               if (rsp_payload.out_length !== oldest.out_length) begin
                  $error("out_length: expected %0d, actual %0d",
                         oldest.out_length, rsp_payload.out_length);
                  mismatch_count++;
               end
               if (rsp_payload.last !== oldest.last) begin
                  $error("last: expected %b, actual %b", oldest.last, rsp_payload.last);
                  mismatch_count++;
               end
            end
         end

         if (req_valid && !req_stall) encode_request(req_payload);
      end
      records_due <= owed_records.size();
   end

endmodule

FILE: tb/run_length_record_encoder_tb.sv
`timescale 1ns / 100ps
module run_length_record_encoder_tb;
   import rlre_pkg::*;

   localparam int CYCLE_LIMIT     = 500_000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_FIRST = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LAST  = 2'd3;
   localparam len_type LONGEST_RUN = '1;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload      = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   rsp_payload_type           rsp_payload;

   int      records_due;
   int      mismatch_count;
   int      cycle_count     = 0;
   int      stall_left      = 0;
   bit      steady_sender   = 1'b0;
   bit      steady_receiver = 1'b0;
   sym_type last_symbol     = '0;
   sym_type symbol_pool[4];

   run_length_record_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   run_length_record_encoder_checker record_monitor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .records_due      (records_due),
      .mismatch_count   (mismatch_count)
   );

   always #5 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // After each accepted record the receiver holds off for a random number
   // of cycles, or not at all while it is in its steady mode.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         stall_left = steady_receiver ? 0 : $urandom_range(0, 6);
         rsp_stall <= (stall_left != 0);
      end else if (rsp_stall) begin
         stall_left = stall_left - 1;
         rsp_stall <= (stall_left != 0);
      end
   end

   // Presents one request after a random gap and returns once it is taken.
   task automatic send_request(input logic op, input sym_type symbol, input len_type length);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {op, symbol, length};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops sending and waits until every owed record has come out.
   task automatic wait_for_records();
      req_valid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers, then junk to an unused index, in back-to-back cycles.
   task automatic program_registers(input logic [CSR_DATA_BITS-1:0] sym_setting,
                                    input logic [CSR_DATA_BITS-1:0] run_setting);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYM_BYTES;
      csr_write_data   <= sym_setting;
      @(posedge clock);
      csr_index      <= CSR_RUN_BYTES;
      csr_write_data <= run_setting;
      @(posedge clock);
      csr_index      <= CSR_INDEX_BITS'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST));
      csr_write_data <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly continues the current run so that runs grow and split; now and
   // then switches symbol or flushes.
   task automatic send_random_request();
      int      pick;
      sym_type symbol;
      len_type length;
      pick = $urandom_range(0, 99);
      if (pick < 70) symbol = last_symbol;
      else if (pick < 90) symbol = symbol_pool[$urandom_range(0, 3)];
      else symbol = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 30) length = len_type'($urandom_range(0, 3));
      else if (pick < 60) length = len_type'($urandom_range(0, 300));
      else if (pick < 85) length = len_type'($urandom);
      else length = LONGEST_RUN;
      if ($urandom_range(0, 99) < 12) begin
         send_request(OP_FLUSH, {$urandom, $urandom}, len_type'($urandom));
      end else begin
         last_symbol = symbol;
         send_request(OP_ADD, symbol, length);
      end
   endtask

   initial begin
      int                       phase;
      logic [CSR_DATA_BITS-1:0] sym_settings[PHASES];
      logic [CSR_DATA_BITS-1:0] run_settings[PHASES];
      sym_type                  sym_a;
      sym_type                  sym_b;

      // Out-of-range values and a run_bytes with its dropped top bit set are
      // among the settings; the last two phases are drawn at random.
      sym_settings = '{4'd0, 4'd8, 4'd15, 4'd9, 4'd2, 4'd4, 4'd7, 4'd1};
      run_settings = '{4'd0, 4'd4, 4'd7, 4'd5, 4'd3, 4'd12, 4'd8, 4'd2};
      sym_settings[PHASES-2] = CSR_DATA_BITS'($urandom);
      run_settings[PHASES-2] = CSR_DATA_BITS'($urandom);
      sym_settings[PHASES-1] = CSR_DATA_BITS'($urandom);
      run_settings[PHASES-1] = CSR_DATA_BITS'($urandom);
      sym_a = 64'hFEDC_BA98_7654_3201;
      sym_b = 64'h0123_4567_89AB_CDEF;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: one-byte symbols and lengths.
      send_request(OP_FLUSH, '1, LONGEST_RUN);        // nothing pending yet
      send_request(OP_ADD, '1, '0);                   // empty run opens
      send_request(OP_ADD, '0, '0);                   // empty run closes silently
      send_request(OP_ADD, '0, LONGEST_RUN);          // longest input splits
      send_request(OP_ADD, '0, 13'd300);
      send_request(OP_ADD, sym_a, 13'd1);             // symbol change
      send_request(OP_ADD, sym_a, 13'd254);           // exactly at the limit
      send_request(OP_ADD, sym_a, 13'd1);             // one over the limit
      send_request(OP_FLUSH, '0, '0);
      send_request(OP_FLUSH, '0, '0);                 // flush after flush
      send_request(OP_ADD, sym_b, 13'd255);
      send_request(OP_ADD, sym_b ^ 64'd1, LONGEST_RUN);
      send_request(OP_ADD, sym_b ^ 64'd1, 13'd224);
      send_request(OP_ADD, sym_b ^ 64'd1, LONGEST_RUN); // most records per request
      send_request(OP_ADD, sym_b ^ (64'd1 << 63), 13'd5); // differs only above the mask
      send_request(OP_ADD, sym_b, '0);
      send_request(OP_FLUSH, sym_b, LONGEST_RUN);

      // Full-width symbols and two-byte lengths, then shrink the limit under a
      // pending run so that its excess is dropped.
      wait_for_records();
      program_registers(4'd8, 4'd2);
      send_request(OP_ADD, sym_a, LONGEST_RUN);
      send_request(OP_ADD, sym_a, LONGEST_RUN);
      wait_for_records();
      program_registers(4'd8, 4'd1);
      send_request(OP_FLUSH, '0, '0);

      // Random phases, each under its own settings and idling pattern.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_records();
         program_registers(sym_settings[phase], run_settings[phase]);
         steady_sender   = (phase == 1) || ($urandom_range(0, 3) == 0);
         steady_receiver = (phase == 2) || ($urandom_range(0, 3) == 0);
         // Pairs of symbols that differ in a single bit, often above the mask.
         symbol_pool[0] = {$urandom, $urandom};
         symbol_pool[1] = symbol_pool[0] ^ (64'd1 << $urandom_range(8, 63));
         symbol_pool[2] = {$urandom, $urandom};
         symbol_pool[3] = symbol_pool[2] ^ (64'd1 << $urandom_range(0, 63));
         last_symbol    = symbol_pool[0];
         repeat (ITEMS_PER_PHASE) send_random_request();
      end

      wait_for_records();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
